// File: rtl/bgi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bgi_pkg;

    localparam int POS_W     = 32;
    localparam int VAL_W     = 32;
    localparam int INV_W     = 24;
    localparam int DIMCFG_W  = 7;
    localparam int NODE_W    = 6;
    localparam int KIND_W    = 2;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int FRAC_BITS = 16;
    localparam int CELL_W    = 16;
    localparam int WGT_W     = 33;
    localparam int MA_W      = 34;
    localparam int MB_W      = 33;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int SUM_W     = 66;
    localparam int ACC_W     = 98;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [WGT_W-1:0] W_ONE  = WGT_W'(65536);
    localparam logic signed [WGT_W-1:0] W_ZERO = '0;

    typedef struct packed {
        logic [DIMCFG_W-1:0] grid_width;
        logic [DIMCFG_W-1:0] grid_height;
        logic [INV_W-1:0]    inv_spacing;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    typedef struct packed {
        logic [CELL_W-1:0]        idx;
        logic                     at_end;
        logic signed [WGT_W-1:0]  w_lo;
        logic signed [WGT_W-1:0]  w_hi;
    } t_axis;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_AXIS_X,
        ST_AXIS_Y,
        ST_RD_A,
        ST_RD_B,
        ST_MUL_B,
        ST_SUM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC_HI,
        ST_FIN
    } t_state;

    // Scaled product back to a Q16.16 grid position, saturated to 32 bits.
    function automatic logic signed [POS_W-1:0] sat_grid(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-FRAC_BITS-1:0] q;
        logic [PROD_W-FRAC_BITS-POS_W:0] hi;
        logic signed [POS_W-1:0] r;
        q  = p[PROD_W-1:FRAC_BITS];
        hi = q[PROD_W-FRAC_BITS-1:POS_W-1];
        if ((&hi) || !(|hi)) begin
            r = q[POS_W-1:0];
        end else if (q[PROD_W-FRAC_BITS-1]) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Cell index, clamped, and the two blend weights along one axis.
    function automatic t_axis cell_axis(input logic signed [POS_W-1:0] g,
                                        input logic [CELL_W-1:0] lim);
        logic signed [CELL_W-1:0] c;
        logic [CELL_W-1:0]        idx;
        logic [CELL_W-1:0]        idx1;
        logic signed [WGT_W-1:0]  f;
        logic signed [WGT_W-1:0]  t;
        t_axis                    r;
        c = g[POS_W-1:FRAC_BITS];
        if (c < 0) begin
            idx = '0;
        end else if (c > $signed(lim)) begin
            idx = lim;
        end else begin
            idx = c;
        end
        idx1     = idx + CELL_W'(1);
        f        = WGT_W'(g) - $signed({1'b0, idx, {FRAC_BITS{1'b0}}});
        t        = $signed({1'b0, idx1, {FRAC_BITS{1'b0}}}) - WGT_W'(g);
        r.idx    = idx;
        r.at_end = (idx == lim);
        r.w_lo   = r.at_end ? W_ONE : t;
        r.w_hi   = r.at_end ? W_ZERO : f;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bgi_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/bgi_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module bgi_mul (
    input  logic                               i_clk,
    input  logic signed [bgi_pkg::MA_W-1:0]    i_a,
    input  logic signed [bgi_pkg::MB_W-1:0]    i_b,
    output logic signed [bgi_pkg::PROD_W-1:0]  o_prod
);
    import bgi_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: rtl/bgi_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module bgi_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bgi_pkg::APB_AW-1:0]  paddr,
    input  logic [bgi_pkg::APB_DW-1:0]  pwdata,
    output logic [bgi_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output bgi_pkg::t_cfg               o_cfg
);
    import bgi_pkg::*;

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INV_SPACING = 2'd2;

    logic [DIMCFG_W-1:0] r_grid_width;
    logic [DIMCFG_W-1:0] r_grid_height;
    logic [INV_W-1:0]    r_inv_spacing;
    logic [1:0]          reg_idx;
    logic                wr_beat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_beat = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= DIMCFG_W'(64);
            r_grid_height <= DIMCFG_W'(64);
            r_inv_spacing <= INV_W'(65536);
        end else if (wr_beat) begin
            case (reg_idx)
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[DIMCFG_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[DIMCFG_W-1:0];
                REG_INV_SPACING: r_inv_spacing <= pwdata[INV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GRID_WIDTH:  prdata = APB_DW'(r_grid_width);
            REG_GRID_HEIGHT: prdata = APB_DW'(r_grid_height);
            REG_INV_SPACING: prdata = APB_DW'(r_inv_spacing);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.grid_width  = r_grid_width;
    assign o_cfg.grid_height = r_grid_height;
    assign o_cfg.inv_spacing = r_inv_spacing;

endmodule

`default_nettype wire

// File: rtl/bgi_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bgi_core #(
    parameter int MAX_DIM    = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bgi_pkg::t_cfg                      i_cfg,
    input  logic                               i_start,
    input  logic                               i_opcode,
    input  logic [bgi_pkg::NODE_W-1:0]         i_node_x,
    input  logic [bgi_pkg::NODE_W-1:0]         i_node_y,
    input  logic signed [bgi_pkg::VAL_W-1:0]   i_node_value,
    input  logic signed [bgi_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [bgi_pkg::POS_W-1:0]   i_pos_y,
    input  logic                               i_out_free,
    output bgi_pkg::t_core_stat                o_stat,
    output logic signed [bgi_pkg::VAL_W-1:0]   o_value,
    output logic [bgi_pkg::KIND_W-1:0]         o_kind
);
    import bgi_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int FAW   = 2 * IDX_W + 2;
    localparam int QW    = ACC_W - 2 * FRAC_BITS;
    localparam logic [QW-1:0] VMAX = (QW'(1) << (VALUE_BITS - 1)) - QW'(1);
    localparam logic [QW-1:0] VMIN = ~VMAX;

    localparam logic [KIND_W-1:0] KIND_INTERIOR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RIGHT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOP      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CORNER   = 2'd3;

    function automatic logic [AW-1:0] node_addr(input logic [IDX_W:0] x,
                                                input logic [IDX_W:0] y);
        logic [FAW-1:0] full;
        full = FAW'(y) * FAW'(MAX_DIM) + FAW'(x);
        return full[AW-1:0];
    endfunction

    function automatic logic [CELL_W-1:0] dim_lim(input logic [DIMCFG_W-1:0] d);
        logic [CELL_W-1:0] dz;
        dz = CELL_W'(d);
        if (dz == '0) begin
            dz = CELL_W'(1);
        end else if (dz > CELL_W'(MAX_DIM)) begin
            dz = CELL_W'(MAX_DIM);
        end
        return dz - CELL_W'(1);
    endfunction

    t_state                   r_state;
    t_state                   n_state;
    logic signed [POS_W-1:0]  r_pos_x;
    logic signed [POS_W-1:0]  r_pos_y;
    logic signed [POS_W-1:0]  r_gx;
    logic signed [POS_W-1:0]  r_gy;
    logic [IDX_W-1:0]         r_i;
    logic [IDX_W-1:0]         r_j;
    logic                     r_end_x;
    logic                     r_end_y;
    logic signed [WGT_W-1:0]  r_ax;
    logic signed [WGT_W-1:0]  r_bx;
    logic signed [WGT_W-1:0]  r_ay;
    logic signed [WGT_W-1:0]  r_by;
    logic                     r_row;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic                     ram_re;
    logic                     rd_col;
    logic [AW-1:0]            ram_raddr;
    logic [VAL_W-1:0]         ram_rdata;
    logic                     load_ok;
    logic                     row_en;
    logic                     col0_en;
    logic                     col1_en;
    logic signed [WGT_W-1:0]  wy;
    logic [CELL_W-1:0]        lim_x;
    logic [CELL_W-1:0]        lim_y;
    t_axis                    axis_res;
    logic [QW-1:0]            q;
    logic [QW-VALUE_BITS:0]   q_hi;
    logic [QW-1:0]            q_sat;
    logic                     done;

    assign lim_x   = dim_lim(i_cfg.grid_width);
    assign lim_y   = dim_lim(i_cfg.grid_height);
    assign row_en  = !r_row || !r_end_y;
    assign col0_en = row_en;
    assign col1_en = row_en && !r_end_x;
    assign wy      = r_row ? r_by : r_ay;

    assign axis_res = (r_state == ST_AXIS_X) ? cell_axis(r_gx, lim_x) : cell_axis(r_gy, lim_y);

    assign load_ok   = (32'(i_node_x) < 32'(MAX_DIM)) && (32'(i_node_y) < 32'(MAX_DIM));
    assign ram_we    = i_start && (i_opcode == OP_LOAD) && load_ok;
    assign ram_waddr = node_addr((IDX_W + 1)'(i_node_x), (IDX_W + 1)'(i_node_y));
    assign ram_raddr = node_addr({1'b0, r_i} + (IDX_W + 1)'(rd_col),
                                 {1'b0, r_j} + (IDX_W + 1)'(r_row));

    bgi_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_node_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bgi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        ram_re  = 1'b0;
        rd_col  = 1'b0;
        done    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start && (i_opcode == OP_QUERY)) begin
                    n_state = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                mul_a   = MA_W'(r_pos_x);
                mul_b   = MB_W'(i_cfg.inv_spacing);
                n_state = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                mul_a   = MA_W'(r_pos_y);
                mul_b   = MB_W'(i_cfg.inv_spacing);
                n_state = ST_AXIS_X;
            end
            ST_AXIS_X: n_state = ST_AXIS_Y;
            ST_AXIS_Y: n_state = ST_RD_A;
            ST_RD_A: begin
                ram_re  = 1'b1;
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                ram_re  = 1'b1;
                rd_col  = 1'b1;
                mul_a   = col0_en ? MA_W'($signed(ram_rdata)) : '0;
                mul_b   = r_ax;
                n_state = ST_MUL_B;
            end
            ST_MUL_B: begin
                mul_a   = col1_en ? MA_W'($signed(ram_rdata)) : '0;
                mul_b   = r_bx;
                n_state = ST_SUM;
            end
            ST_SUM: n_state = ST_MUL_LO;
            ST_MUL_LO: begin
                mul_a   = {2'b00, r_sum[31:0]};
                mul_b   = wy;
                n_state = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                mul_a   = r_sum[SUM_W-1:32];
                mul_b   = wy;
                n_state = ST_ACC_HI;
            end
            ST_ACC_HI: n_state = r_row ? ST_FIN : ST_RD_A;
            ST_FIN: begin
                if (i_out_free) begin
                    done    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_pos_x <= i_pos_x;
                    r_pos_y <= i_pos_y;
                end
            end
            ST_MUL_X: r_acc <= '0;
            ST_MUL_Y: r_gx <= sat_grid(prod);
            ST_AXIS_X: begin
                r_gy    <= sat_grid(prod);
                r_i     <= axis_res.idx[IDX_W-1:0];
                r_end_x <= axis_res.at_end;
                r_ax    <= axis_res.w_lo;
                r_bx    <= axis_res.w_hi;
            end
            ST_AXIS_Y: begin
                r_j     <= axis_res.idx[IDX_W-1:0];
                r_end_y <= axis_res.at_end;
                r_ay    <= axis_res.w_lo;
                r_by    <= axis_res.w_hi;
            end
            ST_MUL_B:  r_sum <= prod[SUM_W-1:0];
            ST_SUM:    r_sum <= r_sum + prod[SUM_W-1:0];
            ST_MUL_HI: r_acc <= r_acc + ACC_W'(prod);
            ST_ACC_HI: r_acc <= r_acc + $signed({prod[ACC_W-33:0], 32'b0});
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 1'b0;
        end else if (r_state == ST_MUL_X) begin
            r_row <= 1'b0;
        end else if (r_state == ST_ACC_HI) begin
            r_row <= 1'b1;
        end
    end

    assign q     = r_acc[ACC_W-1:2*FRAC_BITS];
    assign q_hi  = q[QW-1:VALUE_BITS-1];
    assign q_sat = ((&q_hi) || !(|q_hi)) ? q : (q[QW-1] ? VMIN : VMAX);

    always_comb begin
        case ({r_end_y, r_end_x})
            2'b00:   o_kind = KIND_INTERIOR;
            2'b01:   o_kind = KIND_RIGHT;
            2'b10:   o_kind = KIND_TOP;
            default: o_kind = KIND_CORNER;
        endcase
    end

    assign o_value     = q_sat[VAL_W-1:0];
    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.done = done;

endmodule

`default_nettype wire

// File: rtl/bilinear_grid_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none

// Bilinear interpolator over a grid of Q16.16 node values held in one
// MAX_DIM x MAX_DIM memory. A load beat writes one node as it is accepted and
// the block stays ready for the next beat. A query beat occupies the block:
// it scales x and y by the inverse spacing, finds the cell and blend weights,
// then for each of the two grid rows reads nodes, multiplies and accumulates,
// and finally saturates the sum into the result register. All products go
// through one registered 34x33 multiplier and all node reads through one
// memory read port, so the steps run in sequence. The result register lets a
// new beat be accepted while a result waits; a query finishing while that
// register is still full holds until it drains. The node memory has no reset:
// every node a query touches must be loaded first. Edge cells blend two nodes
// and the last corner returns its node. Below the first node the weights
// extrapolate and the result saturates; past the last the edge node holds.
module bilinear_grid_interpolator #(
    parameter int MAX_DIM    = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bgi_pkg::APB_AW-1:0]        paddr,
    input  logic [bgi_pkg::APB_DW-1:0]        pwdata,
    output logic [bgi_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [bgi_pkg::NODE_W-1:0]        i_node_x,
    input  logic [bgi_pkg::NODE_W-1:0]        i_node_y,
    input  logic signed [bgi_pkg::VAL_W-1:0]  i_node_value,
    input  logic signed [bgi_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [bgi_pkg::POS_W-1:0]  i_pos_y,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [bgi_pkg::VAL_W-1:0]  o_interp_value,
    output logic [bgi_pkg::KIND_W-1:0]        o_cell_kind
);
    import bgi_pkg::*;

    t_cfg                    cfg;
    t_core_stat              stat;
    logic                    in_beat;
    logic                    out_free;
    logic signed [VAL_W-1:0] core_value;
    logic [KIND_W-1:0]       core_kind;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic [KIND_W-1:0]       r_out_kind;

    bgi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_in_ready = !stat.busy;
    assign in_beat    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    bgi_core #(
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_start      (in_beat),
        .i_opcode     (i_opcode),
        .i_node_x     (i_node_x),
        .i_node_y     (i_node_y),
        .i_node_value (i_node_value),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_out_free   (out_free),
        .o_stat       (stat),
        .o_value      (core_value),
        .o_kind       (core_kind)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done) begin
            r_out_value <= core_value;
            r_out_kind  <= core_kind;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_interp_value = r_out_value;
    assign o_cell_kind    = r_out_kind;

`ifndef SYNTHESIS
    a_done_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a waiting beat");

    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_opcode == OP_QUERY)) |=> !o_in_ready)
        else $error("query beat did not start the sequencer");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_opcode == OP_LOAD)) |=> (o_in_ready && !stat.done))
        else $error("load beat disturbed the sequencer");
`endif

endmodule

`default_nettype wire
